// ----- design/bwaa_pkg.sv -----
// ----------------------------------------------------------------------------
// bwaa_pkg
// shared widths, register indexes and word layouts for the box window
// alpha antialias block
// ----------------------------------------------------------------------------
package bwaa_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_WINDOW_DEF = 4;
  localparam int MAX_HEIGHT     = 4096;

  localparam int PIX_W  = 32;   // rgba word
  localparam int CH_W   = 8;    // one color channel
  localparam int RGB_W  = 24;
  localparam int ACOL_W = 10;
  localparam int AROW_W = 12;
  localparam int K_W    = 3;    // window side
  localparam int WS_W   = 3;
  localparam int IW_W   = 11;
  localparam int IH_W   = 13;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int OUT_TDATA_W = 56;

  // floor(s / 9) == (s * 3641) >> 15 for every 12-bit window sum
  localparam int RECIP_NINE       = 3641;
  localparam int RECIP_NINE_W     = 12;
  localparam int RECIP_NINE_SHIFT = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_SIZE  = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } cfg_reg_t;

  // per-item control that travels down the pipeline
  typedef struct packed {
    logic              valid;
    logic              emit;
    logic [ACOL_W-1:0] acol;
    logic [AROW_W-1:0] arow;
  } tag_t;

  // output word, anchor_col in the lowest bits
  typedef struct packed {
    logic [CH_W-1:0]   alpha;
    logic [CH_W-1:0]   blue;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   red;
    logic [AROW_W-1:0] arow;
    logic [ACOL_W-1:0] acol;
  } result_t;

endpackage

// ----- design/bwaa_line_store.sv -----
// ----------------------------------------------------------------------------
// bwaa_line_store
// line store: one word per column holding the previous rows, one lane per row
// ----------------------------------------------------------------------------
module bwaa_line_store #(
  parameter int MAX_WIDTH  = bwaa_pkg::MAX_WIDTH_DEF,
  parameter int MAX_WINDOW = bwaa_pkg::MAX_WINDOW_DEF
) (
  input  logic                                          clk,
  input  logic                                          en,
  input  logic [$clog2(MAX_WIDTH)-1:0]                  addr,
  input  logic [((MAX_WINDOW > 2) ? $clog2(MAX_WINDOW-1) : 1)-1:0] lane,
  input  logic [bwaa_pkg::PIX_W-1:0]                    wr_data,
  output logic [(MAX_WINDOW-1)*bwaa_pkg::PIX_W-1:0]     rd_data
);
  import bwaa_pkg::*;

  localparam int STORE_ROWS = MAX_WINDOW - 1;

  logic [STORE_ROWS*PIX_W-1:0] mem [MAX_WIDTH];

  // read-first: the lane being overwritten still returns its old row
  always_ff @(posedge clk) begin
    if (en) begin
      rd_data <= mem[addr];
      mem[addr][lane*PIX_W +: PIX_W] <= wr_data;
    end
  end

endmodule

// ----- design/bwaa_window.sv -----
// ----------------------------------------------------------------------------
// bwaa_window
// alpha shift window and top row colors, masked per-row sums
// ----------------------------------------------------------------------------
module bwaa_window #(
  parameter int MAX_WINDOW = bwaa_pkg::MAX_WINDOW_DEF
) (
  input  logic                                          clk,
  input  logic                                          load,
  input  logic                                          adv,
  input  logic [bwaa_pkg::PIX_W-1:0]                    pix,
  input  logic [((MAX_WINDOW > 2) ? $clog2(MAX_WINDOW-1) : 1)-1:0] slot,
  input  logic [(MAX_WINDOW-1)*bwaa_pkg::PIX_W-1:0]     rd_data,
  input  logic [bwaa_pkg::K_W-1:0]                      k,
  output logic [MAX_WINDOW-1:0][bwaa_pkg::CH_W+$clog2(MAX_WINDOW)-1:0] rowsum,
  output logic [bwaa_pkg::RGB_W-1:0]                    anchor
);
  import bwaa_pkg::*;

  localparam int STORE_ROWS = MAX_WINDOW - 1;
  localparam int SLOT_W     = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;
  localparam int AB_W       = $clog2(MAX_WINDOW);
  localparam int ROW_W      = CH_W + $clog2(MAX_WINDOW);

  logic [PIX_W-1:0] above [MAX_WINDOW];
  logic [CH_W-1:0]  win   [MAX_WINDOW][MAX_WINDOW];
  logic [RGB_W-1:0] top   [MAX_WINDOW];
  logic [MAX_WINDOW-1:0][ROW_W-1:0] rowsum_c;

  // column of the new pixel and the rows above it
  always_comb begin
    logic [SLOT_W:0] ln;
    above[0] = pix;
    for (int d = 1; d < MAX_WINDOW; d++) begin
      ln = {1'b0, slot} + (SLOT_W+1)'(STORE_ROWS - d);
      if (ln >= (SLOT_W+1)'(STORE_ROWS)) ln = ln - (SLOT_W+1)'(STORE_ROWS);
      above[d] = rd_data[ln*PIX_W +: PIX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int d = 0; d < MAX_WINDOW; d++) begin
        for (int j = 0; j < MAX_WINDOW - 1; j++) win[d][j] <= win[d][j+1];
        win[d][MAX_WINDOW-1] <= above[d][PIX_W-1 -: CH_W];
      end
      for (int j = 0; j < MAX_WINDOW - 1; j++) top[j] <= top[j+1];
      top[MAX_WINDOW-1] <= above[AB_W'(k - K_W'(1))][RGB_W-1:0];
    end
  end

  // only the k rows and the newest k columns count
  always_comb begin
    for (int d = 0; d < MAX_WINDOW; d++) begin
      rowsum_c[d] = '0;
      for (int j = 0; j < MAX_WINDOW; j++) begin
        if ((K_W'(d) < k) && ((K_W'(j) + k) >= K_W'(MAX_WINDOW))) begin
          rowsum_c[d] = rowsum_c[d] + ROW_W'(win[d][j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rowsum <= rowsum_c;
      anchor <= top[AB_W'(K_W'(MAX_WINDOW) - k)];
    end
  end

endmodule

// ----- design/bwaa_mean.sv -----
// ----------------------------------------------------------------------------
// bwaa_mean
// window total, division by k squared and whitening of the anchor color
// ----------------------------------------------------------------------------
module bwaa_mean #(
  parameter int MAX_WINDOW = bwaa_pkg::MAX_WINDOW_DEF
) (
  input  logic                                          clk,
  input  logic                                          adv,
  input  logic [MAX_WINDOW-1:0][bwaa_pkg::CH_W+$clog2(MAX_WINDOW)-1:0] rowsum,
  input  logic [bwaa_pkg::RGB_W-1:0]                    anchor,
  input  logic [bwaa_pkg::K_W-1:0]                      k,
  output logic [bwaa_pkg::CH_W-1:0]                     alpha,
  output logic [bwaa_pkg::RGB_W-1:0]                    rgb
);
  import bwaa_pkg::*;

  localparam int ROW_W  = CH_W + $clog2(MAX_WINDOW);
  localparam int SUM_W  = ROW_W + $clog2(MAX_WINDOW);
  localparam int PROD_W = SUM_W + RECIP_NINE_W;

  logic [SUM_W-1:0]  total_c;
  logic [SUM_W-1:0]  total;
  logic [RGB_W-1:0]  anchor_q;
  logic [PROD_W-1:0] prod;

  always_comb begin
    total_c = '0;
    for (int d = 0; d < MAX_WINDOW; d++) total_c = total_c + SUM_W'(rowsum[d]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      total    <= total_c;
      anchor_q <= anchor;
    end
  end

  assign prod = PROD_W'(total) * PROD_W'(RECIP_NINE);

  always_comb begin
    case (k)
      3'd4:    alpha = CH_W'(total >> 4);
      3'd3:    alpha = CH_W'(prod >> RECIP_NINE_SHIFT);
      default: alpha = CH_W'(total >> 2);
    endcase
    rgb = (alpha != '0) ? '1 : anchor_q;
  end

endmodule

// ----- design/box_window_alpha_antialias_top.sv -----
// ----------------------------------------------------------------------------
// box_window_alpha_antialias_top
// streaming k-by-k box mean of alpha over an rgba raster, whitening pixels
// whose mean alpha is nonzero
// ----------------------------------------------------------------------------
//  channel  | direction | word                        | accepted when
//  ---------+-----------+-----------------------------+----------------------
//  s_*      | in        | rgba pixel, tuser frame flag | s_tvalid && s_tready
//  m_*      | out       | anchor position and color   | m_tvalid && m_tready
//  cfg_*    | in        | register index and value    | cfg_valid && cfg_ready
//
//  one pixel per cycle sustained while no skid word is held; the line store is
//  read and written once per pixel at its column address, so the pixel rate is
//  set by that single port; a result passes the line store, window, row sum,
//  total and output registers to m_tdata; reset clears counters, pipeline tags
//  and valid flags and loads config defaults; the line store is not cleared,
//  rows are written before any window reads them; the output register plus a
//  skid word absorb a stall; s_tready drops only while the skid word is held
// ----------------------------------------------------------------------------
module box_window_alpha_antialias_top #(
  parameter int MAX_WIDTH  = bwaa_pkg::MAX_WIDTH_DEF,
  parameter int MAX_WINDOW = bwaa_pkg::MAX_WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // red_in, green_in, blue_in, alpha_in
  input  logic [bwaa_pkg::PIX_W-1:0]          s_tdata,
  // frame_start
  input  logic [0:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // anchor_col, anchor_row, red_out, green_out, blue_out, alpha_out, 2 pad bits
  output logic [bwaa_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bwaa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bwaa_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bwaa_pkg::*;

  localparam int STORE_ROWS = MAX_WINDOW - 1;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int SLOT_W     = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;
  localparam int WID_W      = (COL_W + 1 > IW_W) ? COL_W + 1 : IW_W;
  localparam int ROW_W      = CH_W + $clog2(MAX_WINDOW);

  // config registers
  logic [WS_W-1:0] window_size;
  logic [IW_W-1:0] image_width;
  logic [IH_W-1:0] image_height;

  // raster position of the next pixel
  logic [COL_W-1:0]  column_count;
  logic [AROW_W-1:0] row_count;
  logic [SLOT_W-1:0] slot_count;   // row_count mod store rows

  logic [K_W-1:0]    k;
  logic [WID_W-1:0]  wid;
  logic [IH_W-1:0]   hgt;

  logic              adv;          // whole pipeline moves
  logic              accept;
  logic [COL_W-1:0]  col_now;
  logic [AROW_W-1:0] row_now;
  logic [SLOT_W-1:0] slot_now;
  logic [SLOT_W-1:0] slot_inc;
  logic              col_last;
  logic              row_last;
  tag_t              tag0;
  tag_t              tag1, tag2, tag3, tag4;

  logic [PIX_W-1:0]  pix1;
  logic [SLOT_W-1:0] slot1;
  logic [STORE_ROWS*PIX_W-1:0] rd_data;
  logic [MAX_WINDOW-1:0][ROW_W-1:0] rowsum;
  logic [RGB_W-1:0]  anchor;
  logic [CH_W-1:0]   mean_alpha;
  logic [RGB_W-1:0]  mean_rgb;

  result_t           res;
  logic              push;
  logic              pop;
  logic              out_valid;
  result_t           out_res;
  logic              skid_valid;
  result_t           skid_res;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size  <= WS_W'(2);
      image_width  <= IW_W'(640);
      image_height <= IH_W'(480);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW_SIZE:  window_size  <= cfg_data[WS_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IW_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[IH_W-1:0];
        default: ;
      endcase
    end
  end

  // effective settings, out-of-range values clamp
  always_comb begin
    if (window_size < WS_W'(2))               k = K_W'(2);
    else if (window_size > WS_W'(MAX_WINDOW)) k = K_W'(MAX_WINDOW);
    else                                      k = K_W'(window_size);

    if (image_width == '0)                           wid = WID_W'(1);
    else if (WID_W'(image_width) > WID_W'(MAX_WIDTH)) wid = WID_W'(MAX_WIDTH);
    else                                             wid = WID_W'(image_width);

    if (image_height == '0)                  hgt = IH_W'(1);
    else if (image_height > IH_W'(MAX_HEIGHT)) hgt = IH_W'(MAX_HEIGHT);
    else                                     hgt = image_height;
  end

  // ---------------------------------------------------------------- raster
  assign s_tready = adv;
  assign accept   = s_tvalid && s_tready;

  // frame start puts this pixel at the origin
  assign col_now  = s_tuser[0] ? '0 : column_count;
  assign row_now  = s_tuser[0] ? '0 : row_count;
  assign slot_now = s_tuser[0] ? '0 : slot_count;

  assign col_last = (WID_W'(col_now) + WID_W'(1)) >= wid;
  assign row_last = (IH_W'(row_now) + IH_W'(1)) >= hgt;
  assign slot_inc = (slot_now == SLOT_W'(STORE_ROWS - 1)) ? '0 : slot_now + SLOT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      slot_count   <= '0;
    end else if (accept) begin
      if (col_last) begin
        column_count <= '0;
        if (row_last) begin
          row_count  <= '0;
          slot_count <= '0;
        end else begin
          row_count  <= row_now + AROW_W'(1);
          slot_count <= slot_inc;
        end
      end else begin
        column_count <= col_now + COL_W'(1);
        row_count    <= row_now;
        slot_count   <= slot_now;
      end
    end
  end

  // anchor sits k-1 columns left and k-1 rows up of the incoming pixel
  always_comb begin
    tag0.valid = s_tvalid;
    tag0.emit  = (WID_W'(col_now) + WID_W'(1) >= WID_W'(k)) &&
                 (IH_W'(row_now) + IH_W'(1) >= IH_W'(k));
    tag0.acol  = ACOL_W'(WID_W'(col_now) + WID_W'(1) - WID_W'(k));
    tag0.arow  = AROW_W'(IH_W'(row_now) + IH_W'(1) - IH_W'(k));
  end

  // -------------------------------------------------------------- pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      tag3 <= '0;
      tag4 <= '0;
    end else if (adv) begin
      tag1 <= tag0;
      tag2 <= tag1;
      tag3 <= tag2;
      tag4 <= tag3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix1  <= s_tdata;
      slot1 <= slot_now;
    end
  end

  bwaa_line_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_line_store (
    .clk     (clk),
    .en      (accept),
    .addr    (col_now),
    .lane    (slot_now),
    .wr_data (s_tdata),
    .rd_data (rd_data)
  );

  bwaa_window #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_window (
    .clk     (clk),
    .load    (adv && tag1.valid),
    .adv     (adv),
    .pix     (pix1),
    .slot    (slot1),
    .rd_data (rd_data),
    .k       (k),
    .rowsum  (rowsum),
    .anchor  (anchor)
  );

  bwaa_mean #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_mean (
    .clk    (clk),
    .adv    (adv),
    .rowsum (rowsum),
    .anchor (anchor),
    .k      (k),
    .alpha  (mean_alpha),
    .rgb    (mean_rgb)
  );

  always_comb begin
    res.acol  = tag4.acol;
    res.arow  = tag4.arow;
    res.red   = mean_rgb[CH_W-1:0];
    res.green = mean_rgb[2*CH_W-1:CH_W];
    res.blue  = mean_rgb[3*CH_W-1:2*CH_W];
    res.alpha = mean_alpha;
  end

  // ---------------------------------------------------- output and skid word
  assign adv  = !skid_valid;
  assign push = adv && tag4.valid && tag4.emit;
  assign pop  = out_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid) begin
      if (skid_valid) out_res <= skid_res;
      else if (push)  out_res <= res;
    end else if (push) begin
      skid_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_TDATA_W'(out_res);

endmodule
